### hdl/heap_sort_engine_top_defines.svh
// Assertion macros used by the verification file of the heap sort engine.
// No dependencies; include with the bare file name.
`ifndef HEAP_SORT_ENGINE_TOP_DEFINES_SVH
`define HEAP_SORT_ENGINE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define HSE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("heap sort engine check failed");

// Property checked on every clock edge, reset included.
`define HSE_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("heap sort engine check failed");

`endif

### hdl/hse_pkg.sv
// Shared types, constants and the signed compare of the heap sort engine.
// No dependencies.
`default_nettype none

package hse_pkg;

   localparam int VALUE_W = 32;

   // Memory port strobes driven by the sequencer
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } hse_mem_ctl_type;

   typedef enum logic [14:0] {
      ST_LOAD     = 15'b000000000000001,
      ST_START    = 15'b000000000000010,
      ST_BUILD    = 15'b000000000000100,
      ST_SD_GETN  = 15'b000000000001000,
      ST_SD_LC    = 15'b000000000010000,
      ST_SD_RC    = 15'b000000000100000,
      ST_SD_CMP   = 15'b000000001000000,
      ST_SD_SWAP  = 15'b000000010000000,
      ST_SD_DONE  = 15'b000000100000000,
      ST_EXTRACT  = 15'b000001000000000,
      ST_EX_RE    = 15'b000010000000000,
      ST_EX_W     = 15'b000100000000000,
      ST_EMIT_RD  = 15'b001000000000000,
      ST_EMIT_OUT = 15'b010000000000000,
      ST_SPARE    = 15'b100000000000000
   } hse_state_type;

   function automatic logic sgt(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

endpackage

`default_nettype wire

### hdl/hse_store.sv
// Value store of the heap sort engine: one write port, one read port,
// read data registered. Depends on hse_pkg.
`default_nettype none

module hse_store
   import hse_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic                clock,
   input  wire hse_mem_ctl_type     mem_ctl,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [VALUE_W-1:0]  wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output logic      [VALUE_W-1:0]  rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/hse_ctrl.sv
// Sequencer of the heap sort engine: loading, heap build, extraction and
// result emission over the value store. Depends on hse_pkg.
`default_nettype none

module hse_ctrl
   import hse_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic                req_last_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_last_out,
   output logic                     rsp_overflow,
   output hse_mem_ctl_type          mem_ctl,
   output logic [AW-1:0]            wr_addr,
   output logic [VALUE_W-1:0]       wr_data,
   output logic [AW-1:0]            rd_addr,
   input  wire logic [VALUE_W-1:0]  rd_data
);

   hse_state_type      state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic               dropped_ff, dropped_in;
   logic [CW-1:0]      iter_ff, iter_in;
   logic [CW-1:0]      size_ff, size_in;
   logic [AW-1:0]      node_ff, node_in;
   logic [AW-1:0]      big_ff, big_in;
   logic [AW-1:0]      k_ff, k_in;
   logic               build_ff, build_in;
   logic [VALUE_W-1:0] nodeval_ff, nodeval_in;
   logic [VALUE_W-1:0] bigval_ff, bigval_in;

   logic [AW+1:0] lc_w, rc_w, size_ext;
   logic          lc_ok, rc_ok, last_k, accept;

   assign lc_w     = {1'b0, node_ff, 1'b1};
   assign rc_w     = lc_w + (AW+2)'(1);
   assign size_ext = (AW+2)'(size_ff);
   assign lc_ok    = lc_w < size_ext;
   assign rc_ok    = rc_w < size_ext;
   assign last_k   = (CW'(k_ff) + CW'(1)) == fill_ff;
   assign accept   = req_valid && req_ready;

   assign req_ready    = (state_ff == ST_LOAD);
   assign rsp_valid    = (state_ff == ST_EMIT_OUT);
   assign rsp_last_out = last_k;
   assign rsp_overflow = dropped_ff;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      dropped_in  = dropped_ff;
      iter_in     = iter_ff;
      size_in     = size_ff;
      node_in     = node_ff;
      big_in      = big_ff;
      k_in        = k_ff;
      build_in    = build_ff;
      nodeval_in  = nodeval_ff;
      bigval_in   = bigval_ff;
      mem_ctl     = '0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_addr     = '0;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (fill_ff < CW'(DEPTH)) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = fill_ff[AW-1:0];
                  wr_data       = req_value;
                  fill_in       = fill_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_in) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            iter_in  = fill_ff >> 1;
            build_in = 1'b1;
            state_in = ST_BUILD;
         end
         ST_BUILD: begin
            if (iter_ff != '0) begin
               node_in        = AW'(iter_ff - CW'(1));
               size_in        = fill_ff;
               mem_ctl.rd_en  = 1'b1;
               rd_addr        = AW'(iter_ff - CW'(1));
               state_in       = ST_SD_GETN;
            end else begin
               iter_in  = fill_ff;
               build_in = 1'b0;
               state_in = ST_EXTRACT;
            end
         end
         ST_SD_GETN: begin
            nodeval_in = rd_data;
            state_in   = ST_SD_LC;
         end
         ST_SD_LC: begin
            if (lc_ok) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = lc_w[AW-1:0];
               state_in      = ST_SD_RC;
            end else begin
               state_in = ST_SD_DONE;
            end
         end
         ST_SD_RC: begin
            if (sgt(rd_data, nodeval_ff)) begin
               big_in    = lc_w[AW-1:0];
               bigval_in = rd_data;
            end else begin
               big_in    = node_ff;
               bigval_in = nodeval_ff;
            end
            if (rc_ok) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = rc_w[AW-1:0];
               state_in      = ST_SD_CMP;
            end else begin
               state_in = ST_SD_SWAP;
            end
         end
         ST_SD_CMP: begin
            if (sgt(rd_data, bigval_ff)) begin
               big_in    = rc_w[AW-1:0];
               bigval_in = rd_data;
            end
            state_in = ST_SD_SWAP;
         end
         ST_SD_SWAP: begin
            // move the larger child up; the sifted value is written once it settles
            if (big_ff == node_ff) begin
               state_in = ST_SD_DONE;
            end else begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = node_ff;
               wr_data       = bigval_ff;
               node_in       = big_ff;
               state_in      = ST_SD_LC;
            end
         end
         ST_SD_DONE: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = node_ff;
            wr_data       = nodeval_ff;
            iter_in       = iter_ff - CW'(1);
            state_in      = build_ff ? ST_BUILD : ST_EXTRACT;
         end
         ST_EXTRACT: begin
            if (iter_ff > CW'(1)) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = '0;
               state_in      = ST_EX_RE;
            end else begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EX_RE: begin
            bigval_in     = rd_data;
            mem_ctl.rd_en = 1'b1;
            rd_addr       = AW'(iter_ff - CW'(1));
            state_in      = ST_EX_W;
         end
         ST_EX_W: begin
            // old root goes to the end; old end value sifts from the root
            mem_ctl.wr_en = 1'b1;
            wr_addr       = AW'(iter_ff - CW'(1));
            wr_data       = bigval_ff;
            nodeval_in    = rd_data;
            node_in       = '0;
            size_in       = iter_ff - CW'(1);
            state_in      = ST_SD_LC;
         end
         ST_EMIT_RD: begin
            mem_ctl.rd_en = 1'b1;
            rd_addr       = k_ff;
            state_in      = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_ready) begin
               if (last_k) begin
                  fill_in    = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
         build_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
         build_ff   <= build_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff    <= iter_in;
      size_ff    <= size_in;
      node_ff    <= node_in;
      big_ff     <= big_in;
      k_ff       <= k_in;
      nodeval_ff <= nodeval_in;
      bigval_ff  <= bigval_in;
   end

endmodule

`default_nettype wire

### hdl/heap_sort_engine_top.sv
// Heap sort engine top level: value store plus sequencer.
// Depends on hse_pkg, hse_store and hse_ctrl.
//
// Usage:
//   Input channel req_*: one signed 32-bit value per transfer; req_last_in
//   closes the set. Up to DEPTH values are kept, later ones are dropped and
//   every result of that run then carries rsp_overflow.
//   Result channel rsp_*: the kept values in ascending order, rsp_last_out
//   on the final one.
//   Loading accepts one value per cycle. After the closing transfer req_ready
//   drops while the heap is built and emptied in place in one memory with a
//   single read and a single write port; each sift-down step reads the
//   children of the node and moves the larger child up if it beats the
//   sifted value. Each result is emitted as a memory read, then the
//   registered word is offered; the next read waits for the transfer.
//   A stalled result is held on rsp_* until the transfer completes.
//   Reset empties the set and returns to loading; no clearing pass is run,
//   the store is only read where it was written in the same run.
`default_nettype none

module heap_sort_engine_top
   import hse_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   input  wire logic                       req_last_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]       rsp_sorted_value,
   output logic                            rsp_last_out,
   output logic                            rsp_overflow
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   hse_mem_ctl_type    mem_ctl;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   hse_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hse_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_last_in  (req_last_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_last_out (rsp_last_out),
      .rsp_overflow (rsp_overflow),
      .mem_ctl      (mem_ctl),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   assign rsp_sorted_value = $signed(rd_data);

endmodule

`default_nettype wire

### hdl/hse_checker.sv
// Port-level checks of the heap sort engine, bound to the top level.
// Depends on hse_pkg and heap_sort_engine_top_defines.svh.
`default_nettype none
`include "heap_sort_engine_top_defines.svh"

module hse_checker
   import hse_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_ready,
   input  wire logic                req_last_in,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_ready,
   input  wire logic [VALUE_W-1:0]  rsp_sorted_value,
   input  wire logic                rsp_last_out,
   input  wire logic                rsp_overflow
);

   // loading and emitting never overlap
   `HSE_ASSERT(a_no_overlap, clock, reset, !(req_ready && rsp_valid))

   // reset returns to loading
   `HSE_ASSERT_ALWAYS(a_reset_loads, clock, reset |=> req_ready)

   // closing transfer stops intake
   `HSE_ASSERT(a_close_stops, clock, reset,
      (req_valid && req_ready && req_last_in) |=> !req_ready)

   // final result transfer reopens intake
   `HSE_ASSERT(a_last_reopens, clock, reset,
      (rsp_valid && rsp_ready && rsp_last_out) |=> req_ready)

   // stalled result holds its payload
   `HSE_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sorted_value)
         && $stable(rsp_last_out) && $stable(rsp_overflow)))

endmodule

bind heap_sort_engine_top hse_checker u_hse_checker (.*);

`default_nettype wire
